/* rtl/harris_keypoint_nms_macros.svh */
// assertion macros shared by the keypoint suppression checkers
`ifndef HARRIS_KEYPOINT_NMS_MACROS_SVH
`define HARRIS_KEYPOINT_NMS_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define HKN_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("keypoint nms check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define HKN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("keypoint nms check failed");

`endif

/* rtl/hkn_pkg.sv */
// shared widths, codes and control types of the keypoint suppression block
package hkn_pkg;

  localparam int unsigned PIX_W  = 12;
  localparam int unsigned RESP_W = 8;
  localparam int unsigned DIAM_W = 6;
  localparam int unsigned LIM_W  = 2 * DIAM_W;
  localparam int unsigned OC_W   = 3;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  localparam logic [RESP_W-1:0] MIN_RESPONSE_RST = 8'd100;
  localparam logic [DIAM_W-1:0] DIAMETER_RST     = 6'd6;

  localparam logic [0:0] REG_MIN_RESPONSE = 1'b0;
  localparam logic [0:0] REG_KP_DIAMETER  = 1'b1;

  typedef enum logic [OC_W-1:0] {
    OC_BELOW    = 3'd0,
    OC_APPEND   = 3'd1,
    OC_REPLACE  = 3'd2,
    OC_SUPPRESS = 3'd3,
    OC_FULL     = 3'd4
  } outcome_e;

  typedef struct packed {
    logic load;
    logic add;
  } sqd_ctl_t;

endpackage

/* rtl/hkn_in_if.sv */
// pixel input channel
interface hkn_in_if import hkn_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  pixel_x;
  logic [PIX_W-1:0]  pixel_y;
  logic [RESP_W-1:0] response;
  logic              frame_start;

  modport source (output valid, pixel_x, pixel_y, response, frame_start, input ready);
  modport sink   (input valid, pixel_x, pixel_y, response, frame_start, output ready);
endinterface

/* rtl/hkn_out_if.sv */
// result output channel
interface hkn_out_if import hkn_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OC_W-1:0]   outcome;
  logic [SLOT_W-1:0] slot;
  logic [CNT_W-1:0]  table_count;

  modport source (output valid, outcome, slot, table_count, input ready);
  modport sink   (input valid, outcome, slot, table_count, output ready);
endinterface

/* rtl/hkn_ram.sv */
// generic single-port ram with registered read
module hkn_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/hkn_sqdist.sv */
// shared squared-distance unit: one squarer and an accumulator, dx then dy
module hkn_sqdist import hkn_pkg::*; #(
  parameter int unsigned CW = 12
) (
  input  logic             clk_i,
  input  sqd_ctl_t         ctl_i,
  input  logic [CW-1:0]    a_i,
  input  logic [CW-1:0]    b_i,
  input  logic [LIM_W-1:0] lim_i,
  output logic             hit_o
);

  localparam int unsigned AW = 2 * CW + 1;

  logic [CW-1:0]   diff;
  logic [2*CW-1:0] prod;
  logic [AW-1:0]   acc_q, acc_d;

  assign diff = (a_i >= b_i) ? (a_i - b_i) : (b_i - a_i);
  assign prod = (2*CW)'(diff) * (2*CW)'(diff);

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.load) begin
      acc_d = AW'(prod);
    end else if (ctl_i.add) begin
      acc_d = acc_q + AW'(prod);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign hit_o = acc_q < AW'(lim_i);

endmodule

/* rtl/hkn_ctrl.sv */
// sequencer: threshold, table walk, replace, append, suppress or full, result register
module hkn_ctrl import hkn_pkg::*; #(
  parameter int unsigned MAX_KEYPOINTS = 64,
  parameter int unsigned CW            = 12
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  hkn_in_if.sink                   pix_i,
  hkn_out_if.source                res_o,
  input  logic [RESP_W-1:0]        min_response_i,
  output sqd_ctl_t                 sqd_ctl_o,
  output logic [CW-1:0]            sqd_a_o,
  output logic [CW-1:0]            sqd_b_o,
  input  logic                     hit_i,
  output logic                     ram_we_o,
  output logic                     ram_re_o,
  output logic [$clog2(MAX_KEYPOINTS)-1:0] ram_addr_o,
  output logic [2*CW+RESP_W-1:0]   ram_wdata_o,
  input  logic [2*CW+RESP_W-1:0]   ram_rdata_i
);

  localparam int unsigned IW   = $clog2(MAX_KEYPOINTS);
  localparam int unsigned CNTW = $clog2(MAX_KEYPOINTS + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DX   = 6'b000010,
    S_DY   = 6'b000100,
    S_CMP  = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     px_q, px_d, py_q, py_d;
  logic [RESP_W-1:0] resp_q, resp_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [CNTW-1:0]   count_q, count_d;
  logic              ovl_q, ovl_d;
  outcome_e          outcome_q, outcome_d;
  logic [IW-1:0]     slot_q, slot_d;

  logic              accept;
  logic [CNTW-1:0]   cnt_start;
  logic [CNTW-1:0]   idx_next;
  logic [CW-1:0]     rx, ry;
  logic [RESP_W-1:0] rr;

  assign accept    = pix_i.valid && pix_i.ready;
  assign cnt_start = pix_i.frame_start ? '0 : count_q;
  assign idx_next  = CNTW'(idx_q) + CNTW'(1);

  assign rx = ram_rdata_i[CW-1:0];
  assign ry = ram_rdata_i[2*CW-1:CW];
  assign rr = ram_rdata_i[2*CW+RESP_W-1:2*CW];

  assign ram_wdata_o = {resp_q, py_q, px_q};

  always_comb begin
    state_d    = state_q;
    px_d       = px_q;
    py_d       = py_q;
    resp_d     = resp_q;
    idx_d      = idx_q;
    count_d    = count_q;
    ovl_d      = ovl_q;
    outcome_d  = outcome_q;
    slot_d     = slot_q;
    sqd_ctl_o  = '0;
    sqd_a_o    = px_q;
    sqd_b_o    = rx;
    ram_we_o   = 1'b0;
    ram_re_o   = 1'b0;
    ram_addr_o = idx_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          px_d    = pix_i.pixel_x[CW-1:0];
          py_d    = pix_i.pixel_y[CW-1:0];
          resp_d  = pix_i.response;
          idx_d   = '0;
          ovl_d   = 1'b0;
          slot_d  = '0;
          count_d = cnt_start;
          if (pix_i.response <= min_response_i) begin
            outcome_d = OC_BELOW;
            state_d   = S_OUT;
          end else if (cnt_start == '0) begin
            state_d = S_FIN;
          end else begin
            ram_re_o   = 1'b1;
            ram_addr_o = '0;
            state_d    = S_DX;
          end
        end
      end
      S_DX: begin
        sqd_ctl_o.load = 1'b1;
        state_d        = S_DY;
      end
      S_DY: begin
        sqd_ctl_o.add = 1'b1;
        sqd_a_o       = py_q;
        sqd_b_o       = ry;
        state_d       = S_CMP;
      end
      S_CMP: begin
        if (hit_i && (resp_q > rr)) begin
          ram_we_o  = 1'b1;
          outcome_d = OC_REPLACE;
          slot_d    = idx_q;
          state_d   = S_OUT;
        end else begin
          ovl_d = ovl_q || hit_i;
          if (idx_next == count_q) begin
            state_d = S_FIN;
          end else begin
            idx_d      = idx_next[IW-1:0];
            ram_re_o   = 1'b1;
            ram_addr_o = idx_next[IW-1:0];
            state_d    = S_DX;
          end
        end
      end
      S_FIN: begin
        if (ovl_q) begin
          outcome_d = OC_SUPPRESS;
        end else if (count_q < CNTW'(MAX_KEYPOINTS)) begin
          ram_we_o   = 1'b1;
          ram_addr_o = count_q[IW-1:0];
          outcome_d  = OC_APPEND;
          slot_d     = count_q[IW-1:0];
          count_d    = count_q + CNTW'(1);
        end else begin
          outcome_d = OC_FULL;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (res_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q      <= px_d;
    py_q      <= py_d;
    resp_q    <= resp_d;
    idx_q     <= idx_d;
    ovl_q     <= ovl_d;
    outcome_q <= outcome_d;
    slot_q    <= slot_d;
  end

  assign pix_i.ready       = (state_q == S_IDLE);
  assign res_o.valid       = (state_q == S_OUT);
  assign res_o.outcome     = outcome_q;
  assign res_o.slot        = SLOT_W'(slot_q);
  assign res_o.table_count = CNT_W'(count_q);

endmodule

/* rtl/harris_keypoint_nms.sv */
// top level of the greedy keypoint non-maximum suppression block
// Takes one pixel beat at a time (coordinates, 8-bit corner response, frame
// start flag) and returns one result beat: outcome, slot and table count.
// A pixel at or below min_response gives its result the cycle after it is
// taken. A candidate walks the stored keypoints in slot order through one
// shared squared-distance unit (a single squarer used for dx, then dy, then a
// compare per stored keypoint, with up to 64 in a full table); a replacement
// ends the walk early. The block takes no new pixel until the result beat has
// been taken. Registers on the APB-style port: min_response at 0x0 (reset 100)
// and keypoint_diameter at 0x4 (reset 6).
module harris_keypoint_nms import hkn_pkg::*; #(
  parameter int unsigned MAX_KEYPOINTS = 64,
  parameter int unsigned COORD_BITS    = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  hkn_in_if.sink            pix_i,
  hkn_out_if.source         res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned CW = (COORD_BITS < PIX_W) ? COORD_BITS : PIX_W;
  localparam int unsigned IW = $clog2(MAX_KEYPOINTS);
  localparam int unsigned WW = 2 * CW + RESP_W;

  logic [RESP_W-1:0] min_resp_q;
  logic [DIAM_W-1:0] diam_q;
  logic [LIM_W-1:0]  lim_q;
  logic [DIAM_W-1:0] wr_diam;
  logic              cfg_wr;

  sqd_ctl_t          sqd_ctl;
  logic [CW-1:0]     sqd_a, sqd_b;
  logic              hit;
  logic              ram_we, ram_re;
  logic [IW-1:0]     ram_addr;
  logic [WW-1:0]     ram_wdata, ram_rdata;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign wr_diam = pwdata[DIAM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_resp_q <= MIN_RESPONSE_RST;
      diam_q     <= DIAMETER_RST;
      lim_q      <= LIM_W'(DIAMETER_RST) * LIM_W'(DIAMETER_RST);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_MIN_RESPONSE: begin
          min_resp_q <= pwdata[RESP_W-1:0];
        end
        REG_KP_DIAMETER: begin
          diam_q <= wr_diam;
          lim_q  <= LIM_W'(wr_diam) * LIM_W'(wr_diam);
        end
        default: begin
          min_resp_q <= min_resp_q;
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MIN_RESPONSE: prdata = APB_DW'(min_resp_q);
      REG_KP_DIAMETER:  prdata = APB_DW'(diam_q);
      default:          prdata = '0;
    endcase
  end

  hkn_ctrl #(
    .MAX_KEYPOINTS(MAX_KEYPOINTS),
    .CW           (CW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pix_i         (pix_i),
    .res_o         (res_o),
    .min_response_i(min_resp_q),
    .sqd_ctl_o     (sqd_ctl),
    .sqd_a_o       (sqd_a),
    .sqd_b_o       (sqd_b),
    .hit_i         (hit),
    .ram_we_o      (ram_we),
    .ram_re_o      (ram_re),
    .ram_addr_o    (ram_addr),
    .ram_wdata_o   (ram_wdata),
    .ram_rdata_i   (ram_rdata)
  );

  hkn_sqdist #(
    .CW(CW)
  ) u_sqdist (
    .clk_i(clk_i),
    .ctl_i(sqd_ctl),
    .a_i  (sqd_a),
    .b_i  (sqd_b),
    .lim_i(lim_q),
    .hit_o(hit)
  );

  hkn_ram #(
    .WIDTH(WW),
    .DEPTH(MAX_KEYPOINTS)
  ) u_kp_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

endmodule

/* rtl/hkn_checker.sv */
// port-level checker for the keypoint suppression block, bound to the top
`include "harris_keypoint_nms_macros.svh"

module hkn_checker import hkn_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [OC_W-1:0]   outcome_i,
  input logic [SLOT_W-1:0] slot_i
);

  // result beat holds until taken
  `HKN_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  // no new pixel while a result waits
  `HKN_ASSERT_NOW(a_busy_on_result, out_valid_i, !in_ready_i)
  // a taken pixel closes the input
  `HKN_ASSERT_NEXT(a_busy_after_in, in_valid_i && in_ready_i, !in_ready_i)
  // each result is delivered once
  `HKN_ASSERT_NEXT(a_single_result, out_valid_i && out_ready_i, !out_valid_i)
  // no slot when nothing was written
  `HKN_ASSERT_NOW(a_slot_zero,
    out_valid_i && (outcome_i == OC_BELOW || outcome_i == OC_SUPPRESS ||
    outcome_i == OC_FULL), slot_i == '0)

endmodule

bind harris_keypoint_nms hkn_checker u_hkn_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (pix_i.valid),
  .in_ready_i (pix_i.ready),
  .out_valid_i(res_o.valid),
  .out_ready_i(res_o.ready),
  .outcome_i  (res_o.outcome),
  .slot_i     (res_o.slot)
);

/* tb/harris_keypoint_nms_checker.sv */
// checker for the keypoint suppression block: predicts each result beat and compares
module harris_keypoint_nms_checker import hkn_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  hkn_in_if                 pix,
  hkn_out_if                res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic              pready,
  output int unsigned       mismatches,
  output int unsigned       outcomes_left,
  output int unsigned       beats_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_KP = 64;

  typedef struct packed {
    outcome_e          outcome;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  count;
  } nms_outcome_t;

  logic [PIX_W-1:0]  kp_col  [MAX_KP];
  logic [PIX_W-1:0]  kp_row  [MAX_KP];
  logic [RESP_W-1:0] kp_score[MAX_KP];
  logic [CNT_W-1:0]  kp_count;
  logic [RESP_W-1:0] min_thr;
  logic [DIAM_W-1:0] diam;

  nms_outcome_t pending_outcomes[$];

  function automatic nms_outcome_t walk_keypoints(input logic [PIX_W-1:0] px,
                                                  input logic [PIX_W-1:0] py,
                                                  input logic [RESP_W-1:0] resp,
                                                  input logic fs);
    nms_outcome_t r;
    logic [LIM_W-1:0] lim;
    logic [PIX_W-1:0] dx;
    logic [PIX_W-1:0] dy;
    logic [2*PIX_W:0] d2;
    logic hit;
    logic done;
    int unsigned n;
    int unsigned i;
    r.outcome = OC_BELOW;
    r.slot = '0;
    if (fs) kp_count = '0;
    if (resp > min_thr) begin
      lim = diam * diam;
      hit = 1'b0;
      done = 1'b0;
      n = kp_count;
      if (n > MAX_KP) n = MAX_KP;
      for (i = 0; i < n && !done; i++) begin
        dx = (px > kp_col[i]) ? px - kp_col[i] : kp_col[i] - px;
        dy = (py > kp_row[i]) ? py - kp_row[i] : kp_row[i] - py;
        d2 = dx * dx + dy * dy;
        if (d2 < lim) begin
          hit = 1'b1;
          if (resp > kp_score[i]) begin
            kp_col[i] = px;
            kp_row[i] = py;
            kp_score[i] = resp;
            r.slot = i[SLOT_W-1:0];
            done = 1'b1;
          end
        end
      end
      if (done) begin
        r.outcome = OC_REPLACE;
      end else if (hit) begin
        r.outcome = OC_SUPPRESS;
      end else if (n < MAX_KP) begin
        kp_col[n] = px;
        kp_row[n] = py;
        kp_score[n] = resp;
        r.slot = n[SLOT_W-1:0];
        kp_count = n[CNT_W-1:0] + 1'b1;
        r.outcome = OC_APPEND;
      end else begin
        r.outcome = OC_FULL;
      end
    end
    r.count = kp_count;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    nms_outcome_t want;
    nms_outcome_t next_want;
    if (!rst_ni) begin
      pending_outcomes.delete();
      kp_count = '0;
      min_thr = MIN_RESPONSE_RST;
      diam = DIAMETER_RST;
      mismatches = 0;
      outcomes_left = 0;
      beats_checked = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (pending_outcomes.size() == 0) begin
          $error("result beat with no pixel waiting");
          mismatches++;
        end else begin
          want = pending_outcomes.pop_front();
          beats_checked++;
          if (res.outcome !== want.outcome) begin
            $error("outcome: expected %0d, got %0d", want.outcome, res.outcome);
            mismatches++;
          end
          if (res.slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, res.slot);
            mismatches++;
          end
          if (res.table_count !== want.count) begin
            $error("table_count: expected %0d, got %0d", want.count, res.table_count);
            mismatches++;
          end
        end
      end
      if (pix.valid && pix.ready) begin
        next_want = walk_keypoints(pix.pixel_x, pix.pixel_y, pix.response,
                                   pix.frame_start);
        pending_outcomes = {pending_outcomes, next_want};
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[APB_AW-1:2] == REG_MIN_RESPONSE) begin
          min_thr = pwdata[RESP_W-1:0];
        end else if (paddr[APB_AW-1:2] == REG_KP_DIAMETER) begin
          diam = pwdata[DIAM_W-1:0];
        end
      end
      outcomes_left = pending_outcomes.size();
    end
  end

endmodule

/* tb/harris_keypoint_nms_test.sv */
// testbench top for the keypoint suppression block: clock, reset, stimulus and verdict
module harris_keypoint_nms_test import hkn_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_BEATS = 105;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int unsigned mismatches;
  int unsigned outcomes_left;
  int unsigned beats_checked;
  int unsigned pixel_beats;
  bit          steady;

  hkn_in_if  pix();
  hkn_out_if res();

  harris_keypoint_nms dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix),
    .res_o   (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  harris_keypoint_nms_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pix           (pix),
    .res           (res),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .mismatches    (mismatches),
    .outcomes_left (outcomes_left),
    .beats_checked (beats_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("harris_keypoint_nms test failed");
    $finish;
  end

  // mostly short pauses, a few long ones
  function automatic int unsigned idle_cycles();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return $urandom_range(1, 2);
    if (pick < 90) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned near_coord(input int unsigned c, input int unsigned span);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * span)) - int'(span);
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v;
  endfunction

  initial begin
    int unsigned hold;
    hold = 0;
    res.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (steady) begin
        res.ready <= 1'b1;
        hold = 0;
      end else if (hold > 0) begin
        res.ready <= 1'b0;
        hold--;
      end else begin
        res.ready <= 1'b1;
        if ($urandom_range(0, 99) < 25) hold = idle_cycles();
      end
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y,
                            input logic [RESP_W-1:0] r, input logic fs);
    int unsigned gap;
    gap = (steady || $urandom_range(0, 99) < 60) ? 0 : idle_cycles();
    repeat (gap) begin
      @(negedge clk_i);
      pix.valid <= 1'b0;
    end
    @(negedge clk_i);
    pix.valid       <= 1'b1;
    pix.pixel_x     <= x;
    pix.pixel_y     <= y;
    pix.response    <= r;
    pix.frame_start <= fs;
    do @(posedge clk_i); while (!pix.ready);
    pixel_beats++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    pix.valid <= 1'b0;
    while (outcomes_left != 0) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [0:0] idx, input logic [APB_DW-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // clustered frames give overlaps, spread frames fill the table
  task automatic play_frame(input int unsigned budget, input int unsigned thr,
                            input int unsigned diam, output int unsigned used);
    int unsigned cx[6];
    int unsigned cy[6];
    int unsigned k;
    int unsigned span;
    int unsigned len;
    int unsigned j;
    int unsigned c;
    int unsigned sel;
    int unsigned x;
    int unsigned y;
    int unsigned r;
    int unsigned lx;
    int unsigned ly;
    bit spread;
    logic fs;
    spread = ($urandom_range(0, 3) == 0);
    steady = ($urandom_range(0, 4) == 0);
    len = spread ? $urandom_range(66, 90) : $urandom_range(5, 60);
    if (len > budget) len = budget;
    k = $urandom_range(1, 6);
    for (c = 0; c < 6; c++) begin
      cx[c] = $urandom_range(0, 4095);
      cy[c] = $urandom_range(0, 4095);
    end
    span = diam + 2;
    lx = 0;
    ly = 0;
    for (j = 0; j < len; j++) begin
      sel = $urandom_range(0, 99);
      if (spread || sel < 20) begin
        x = $urandom_range(0, 4095);
        y = $urandom_range(0, 4095);
      end else if (sel < 30 && j > 0) begin
        x = lx;
        y = ly;
      end else begin
        c = $urandom_range(0, k - 1);
        x = near_coord(cx[c], span);
        y = near_coord(cy[c], span);
      end
      if (thr < 255 && $urandom_range(0, 3) != 0) r = $urandom_range(thr + 1, 255);
      else r = $urandom_range(0, 255);
      fs = (j == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 99) < 2);
      send_pixel(x[PIX_W-1:0], y[PIX_W-1:0], r[RESP_W-1:0], fs);
      lx = x;
      ly = y;
    end
    used = len;
  endtask

  initial begin
    int unsigned phase;
    int unsigned left;
    int unsigned used;
    int unsigned thr;
    int unsigned diam;
    pixel_beats     = 0;
    steady          = 1'b0;
    pix.valid       = 1'b0;
    pix.pixel_x     = '0;
    pix.pixel_y     = '0;
    pix.response    = '0;
    pix.frame_start = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    rst_ni          = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed beats at reset settings
    send_pixel(12'd0,    12'd0,    8'd255, 1'b1);
    send_pixel(12'd4095, 12'd4095, 8'd101, 1'b0);
    send_pixel(12'd0,    12'd0,    8'd100, 1'b0);
    send_pixel(12'd3,    12'd3,    8'd200, 1'b0);
    send_pixel(12'd3,    12'd3,    8'd255, 1'b0);
    send_pixel(12'd4095, 12'd4090, 8'd150, 1'b0);
    send_pixel(12'd4095, 12'd4084, 8'd0,   1'b0);
    send_pixel(12'd6,    12'd0,    8'd200, 1'b0);
    send_pixel(12'd5,    12'd0,    8'd254, 1'b0);
    send_pixel(12'hAAA,  12'h555,  8'hAA,  1'b0);
    send_pixel(12'h555,  12'hAAA,  8'h55,  1'b0);
    send_pixel(12'd4095, 12'd0,    8'd255, 1'b0);
    send_pixel(12'd0,    12'd4095, 8'd255, 1'b0);
    send_pixel(12'd0,    12'd0,    8'd0,   1'b1);
    send_pixel(12'd100,  12'd100,  8'd101, 1'b1);
    send_pixel(12'd101,  12'd100,  8'd102, 1'b0);
    drain();
    // zero diameter: identical pixels do not overlap
    apb_write(REG_KP_DIAMETER, 32'd0);
    send_pixel(12'd50, 12'd50, 8'd200, 1'b1);
    send_pixel(12'd50, 12'd50, 8'd210, 1'b0);
    drain();
    apb_write(REG_MIN_RESPONSE, 32'd0);
    apb_write(REG_KP_DIAMETER, 32'd6);
    send_pixel(12'd7, 12'd7, 8'd0, 1'b0);
    send_pixel(12'd7, 12'd7, 8'd1, 1'b0);

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin thr = 100; diam = 6; end
        1: begin thr = 0; diam = 1; end
        2: begin thr = 255; diam = 63; end
        3: begin thr = 0; diam = 63; end
        4: begin thr = 128; diam = 0; end
        5: begin thr = 200; diam = 17; end
        6: begin thr = 37; diam = 32; end
        default: begin thr = $urandom_range(0, 255); diam = $urandom_range(1, 63); end
      endcase
      drain();
      apb_write(REG_MIN_RESPONSE, thr);
      apb_write(REG_KP_DIAMETER, diam);
      left = PHASE_BEATS;
      while (left > 0) begin
        play_frame(left, thr, diam, used);
        left -= used;
      end
    end
    steady = 1'b0;
    drain();
    repeat (200) @(negedge clk_i);

    $display("sent %0d pixel beats under %0d register settings plus directed ones",
             pixel_beats, PHASES);
    $display("checked %0d result beats, %0d mismatches", beats_checked, mismatches);
    if (mismatches == 0 && outcomes_left == 0) begin
      $display("harris_keypoint_nms test passed");
    end else begin
      $display("harris_keypoint_nms test failed");
    end
    $finish;
  end

endmodule
